// ===== rtl/kcl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad code lock package
// Beat types, phase encoding, verdict and mode codes shared by the lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

	localparam int          KEY_W       = 8;
	localparam int          REG_W       = 48;
	localparam int          REG_COUNT   = 4;
	localparam int          CFG_IDX_W   = 2;
	localparam logic [47:0] MASTER_INIT = 48'h414230314344;

	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] key_code;
	} kcl_in_t;

	typedef struct packed {
		logic [2:0] keys_entered;
		logic [1:0] lock_mode;
		logic [2:0] verdict;
	} kcl_out_t;

	typedef enum logic [2:0] {
		PH_ENTRY     = 3'b001,
		PH_NEWMASTER = 3'b010,
		PH_ALARM     = 3'b100
	} kcl_phase_t;

	localparam logic       MODE_KEY   = 1'b0;
	localparam logic       MODE_CLEAR = 1'b1;

	localparam logic [1:0] LM_ENTRY     = 2'd0;
	localparam logic [1:0] LM_NEWMASTER = 2'd1;
	localparam logic [1:0] LM_ALARM     = 2'd2;

	localparam logic [2:0] V_NONE    = 3'd0;
	localparam logic [2:0] V_UNLOCK  = 3'd1;
	localparam logic [2:0] V_ALARM   = 3'd2;
	localparam logic [2:0] V_NEWMODE = 3'd3;
	localparam logic [2:0] V_CHANGED = 3'd4;

endpackage
`default_nettype wire

// ===== rtl/kcl_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad code lock core
// Lock state, code registers and the combinational step that matches an entry
// against the master and user codes.
// ----------------------------------------------------------------------------
module kcl_core
	import kcl_pkg::*;
#(
	parameter int CODE_KEYS  = 6,
	parameter int USER_SLOTS = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire kcl_in_t              beat,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data,
	output kcl_out_t                  result
);

	localparam int CODE_W   = KEY_W * CODE_KEYS;
	localparam int CNT_W    = $clog2(CODE_KEYS + 1);
	localparam int NUM_USER = (USER_SLOTS < REG_COUNT) ? USER_SLOTS : REG_COUNT;

	kcl_phase_t        phase_q, phase_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CODE_W-1:0] entry_q, entry_d;
	logic [CODE_W-1:0] master_q, master_d;
	logic [REG_W-1:0]  user_q [REG_COUNT];
	logic              user_hit;
	logic [2:0]        verdict;
	logic [1:0]        lock_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < REG_COUNT; k++) begin
				user_q[k] <= '0;
			end
		end else if (cfg_we) begin
			user_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		user_hit = 1'b0;
		for (int k = 0; k < NUM_USER; k++) begin
			if (CODE_W'(user_q[k]) == entry_q) begin
				user_hit = 1'b1;
			end
		end
	end

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		entry_d  = entry_q;
		master_d = master_q;
		verdict  = V_NONE;
		case (phase_q)
			PH_ALARM: begin
				if (beat.mode == MODE_CLEAR) begin
					phase_d = PH_ENTRY;
					count_d = '0;
				end
			end
			PH_ENTRY, PH_NEWMASTER: begin
				if (beat.mode == MODE_KEY && beat.key_code != '0) begin
					if (count_q < CNT_W'(CODE_KEYS)) begin
						entry_d = CODE_W'({entry_q, beat.key_code});
						count_d = count_q + CNT_W'(1);
					end else if (phase_q == PH_NEWMASTER) begin
						master_d = entry_q;
						phase_d  = PH_ENTRY;
						count_d  = '0;
						verdict  = V_CHANGED;
					end else begin
						if (entry_q == master_q) begin
							phase_d = PH_NEWMASTER;
							verdict = V_NEWMODE;
						end else if (user_hit) begin
							verdict = V_UNLOCK;
						end else begin
							phase_d = PH_ALARM;
							verdict = V_ALARM;
						end
						count_d = '0;
					end
				end
			end
			default: begin
				phase_d = PH_ENTRY;
				count_d = '0;
			end
		endcase
	end

	always_comb begin
		case (phase_d)
			PH_NEWMASTER: lock_mode = LM_NEWMASTER;
			PH_ALARM:     lock_mode = LM_ALARM;
			default:      lock_mode = LM_ENTRY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ENTRY;
			count_q  <= '0;
			master_q <= CODE_W'(MASTER_INIT);
		end else if (step) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			master_q <= master_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			entry_q <= entry_d;
		end
	end

	assign result.keys_entered = 3'(count_d);
	assign result.lock_mode    = lock_mode;
	assign result.verdict      = verdict;

endmodule
`default_nettype wire

// ===== rtl/keypad_code_lock.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad code lock
// Collects key beats, checks entries against master and user codes.
// ----------------------------------------------------------------------------
// One key or clear beat is taken every cycle unless key_stall is high. The
// whole step (shift the entry, compare with the master and the user codes,
// choose the next phase) is combinational logic in the core. Results pass
// through an output register backed by one skid register, so key_stall comes
// straight from a flop and rises only after the result side has stalled with
// two beats held. User codes reset to zero; the user must write them through
// the cfg port only while the lock is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module keypad_code_lock
	import kcl_pkg::*;
#(
	parameter int CODE_KEYS  = 6,
	parameter int USER_SLOTS = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 key_valid,
	output logic                      key_stall,
	input  wire kcl_in_t              key_beat,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output kcl_out_t                  res_beat,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data
);

	logic     take_in, take_out;
	kcl_out_t step_res;
	logic     out_valid_q, skid_valid_q;
	kcl_out_t out_beat_q, skid_beat_q;

	assign key_stall = skid_valid_q;
	assign take_in   = key_valid && !skid_valid_q;
	assign take_out  = out_valid_q && !res_stall;

	kcl_core #(
		.CODE_KEYS  (CODE_KEYS),
		.USER_SLOTS (USER_SLOTS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (take_in),
		.beat      (key_beat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take_out) begin
				skid_valid_q <= 1'b0;
			end
		end else if (take_in) begin
			if (out_valid_q && !take_out) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take_out) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take_out) begin
				out_beat_q <= skid_beat_q;
			end
		end else if (take_in) begin
			if (out_valid_q && !take_out) begin
				skid_beat_q <= step_res;
			end else begin
				out_beat_q <= step_res;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_beat  = out_beat_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid beat held with empty output register");

	a_fill_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(take_in && out_valid_q && res_stall) |=> (skid_valid_q && out_valid_q))
		else $error("beat taken behind a stalled result was lost");

	a_alarm_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_beat.verdict == V_ALARM)
			|-> (res_beat.lock_mode == LM_ALARM && res_beat.keys_entered == 3'd0))
		else $error("alarm verdict without alarm mode and empty entry");

	a_newmode_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_beat.verdict == V_NEWMODE)
			|-> (res_beat.lock_mode == LM_NEWMASTER && res_beat.keys_entered == 3'd0))
		else $error("new master verdict without new master mode");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code lock testbench
// Drives key and clear beats through the lock, predicts every result beat and
// checks it field by field. Directed tests cover the corner cases. Random
// sessions then type master, user, wrong and near-miss codes, with noise
// mixed in, over four idle/stall phases. The user codes change between phases.
// ----------------------------------------------------------------------------
module tb;
	import kcl_pkg::*;

	localparam int CODE_KEYS   = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BEATS = 300;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              key_valid = 1'b0;
	logic              key_stall;
	kcl_in_t           key_beat  = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	kcl_out_t          res_beat;
	logic              cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]  cfg_data  = '0;

	// lock state as predicted
	logic [1:0]        pred_phase  = LM_ENTRY;
	int                pred_count  = 0;
	logic [REG_W-1:0]  pred_entry  = '0;
	logic [REG_W-1:0]  pred_master = MASTER_INIT;
	logic [REG_W-1:0]  user_code [REG_COUNT] = '{default: '0};

	kcl_out_t          expected_results [$];
	kcl_out_t          oldest;
	int                idle_pct    = 0;
	int                stall_pct   = 0;
	int                live_beats  = 0;
	int                failures    = 0;
	int                verdict_seen [8] = '{default: 0};

	keypad_code_lock i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.key_beat  (key_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("keypad_code_lock regression: fail");
		$finish;
	end

	function automatic kcl_out_t lock_step(input kcl_in_t beat);
		kcl_out_t r;
		logic     hit;
		r.verdict = V_NONE;
		hit = 1'b0;
		if (pred_phase == LM_ALARM) begin
			if (beat.mode == MODE_CLEAR) begin
				pred_phase = LM_ENTRY;
				pred_count = 0;
			end
		end else if (beat.mode == MODE_KEY && beat.key_code != '0) begin
			if (pred_count < CODE_KEYS) begin
				pred_entry = {pred_entry[REG_W-KEY_W-1:0], beat.key_code};
				pred_count++;
			end else if (pred_phase == LM_NEWMASTER) begin
				pred_master = pred_entry;
				pred_phase  = LM_ENTRY;
				pred_count  = 0;
				r.verdict   = V_CHANGED;
			end else begin
				for (int i = 0; i < REG_COUNT; i++)
					if (user_code[i] == pred_entry) hit = 1'b1;
				if (pred_entry == pred_master) begin
					pred_phase = LM_NEWMASTER;
					r.verdict  = V_NEWMODE;
				end else if (hit) begin
					r.verdict = V_UNLOCK;
				end else begin
					pred_phase = LM_ALARM;
					r.verdict  = V_ALARM;
				end
				pred_count = 0;
			end
		end
		r.keys_entered = 3'(pred_count);
		r.lock_mode    = pred_phase;
		return r;
	endfunction

	function automatic logic [REG_W-1:0] random_code();
		logic [REG_W-1:0] c;
		int               pick;
		pick = $urandom_range(9);
		if (pick == 0) return '0;
		if (pick == 1) return '1;
		for (int j = 0; j < CODE_KEYS; j++) c[8*j +: 8] = 8'($urandom_range(1, 255));
		return c;
	endfunction

	task automatic send_beat(input logic m, input logic [KEY_W-1:0] k);
		kcl_in_t    beat;
		logic [1:0] was;
		beat = kcl_in_t'({m, k});
		while ($urandom_range(99) < idle_pct) begin
			key_valid <= 1'b0;
			@(posedge clk);
		end
		key_valid <= 1'b1;
		key_beat  <= beat;
		@(posedge clk);
		while (key_stall !== 1'b0) @(posedge clk);
		was = pred_phase;
		if (m == MODE_KEY ? (k != '0 && was != LM_ALARM) : was == LM_ALARM) live_beats++;
		expected_results.push_back(lock_step(beat));
	endtask

	// hold off until every result beat is back
	task automatic drain();
		key_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_codes(input logic [REG_W-1:0] a, b, c, d);
		logic [REG_W-1:0] vals [REG_COUNT] = '{a, b, c, d};
		for (int i = 0; i < REG_COUNT; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			user_code[i] = vals[i];
		end
		cfg_we <= 1'b0;
	endtask

	task automatic type_code(input logic [REG_W-1:0] code, input logic [KEY_W-1:0] enter_key,
			input int noise_pct);
		logic [KEY_W-1:0] k;
		for (int i = CODE_KEYS - 1; i >= 0; i--) begin
			if ($urandom_range(99) < noise_pct) begin
				if ($urandom_range(1)) send_beat(MODE_KEY, '0);
				else send_beat(MODE_CLEAR, KEY_W'($urandom));
			end
			k = code[8*i +: 8];
			if (k == '0) k = "0";
			send_beat(MODE_KEY, k);
		end
		send_beat(MODE_KEY, enter_key);
	endtask

	task automatic test_register_extremes();
		write_codes('1, '0, "965027", "105131");
	endtask

	task automatic test_ignored_beats();
		send_beat(MODE_KEY, '0);
		send_beat(MODE_CLEAR, 8'hFF);
	endtask

	task automatic test_user_unlock();
		type_code('1, 8'h01, 0);
	endtask

	task automatic test_alarm_and_clear();
		type_code("151712", 8'h80, 0);
		send_beat(MODE_KEY, "7");
		send_beat(MODE_CLEAR, 8'h00);
	endtask

	task automatic test_master_change();
		type_code(MASTER_INIT, "#", 0);
		type_code("686443", "#", 0);
		drain();
	endtask

	task automatic run_session();
		logic [REG_W-1:0] code;
		int               pick;
		int               slot;
		while (pred_count != 0) send_beat(MODE_KEY, KEY_W'($urandom_range(1, 255)));
		if (pred_phase == LM_ALARM) send_beat(MODE_CLEAR, KEY_W'($urandom));
		pick = $urandom_range(99);
		slot = $urandom_range(CODE_KEYS - 1);
		if (pick < 80) begin
			if (pick < 30)      code = user_code[$urandom_range(REG_COUNT - 1)];
			else if (pick < 50) code = pred_master;
			else if (pick < 65) code = random_code();
			else begin
				code = $urandom_range(1) ? pred_master : user_code[$urandom_range(REG_COUNT - 1)];
				code[8*slot +: 8] ^= 8'($urandom_range(1, 255));
			end
			type_code(code, KEY_W'($urandom_range(1, 255)), 8);
		end else begin
			repeat ($urandom_range(1, 5))
				send_beat($urandom_range(3) == 0,
					$urandom_range(4) == 0 ? '0 : KEY_W'($urandom));
		end
	endtask

	task automatic test_random_traffic();
		int idle_set  [4] = '{0, 46, 0, 15};
		int stall_set [4] = '{0, 0, 46, 15};
		int goal;
		for (int p = 0; p < 4; p++) begin
			drain();
			write_codes(random_code(), random_code(), random_code(), random_code());
			idle_pct  = idle_set[p];
			stall_pct = stall_set[p];
			goal = live_beats + PHASE_BEATS;
			while (live_beats < goal) run_session();
		end
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
		if (res_valid === 1'b1 && res_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected");
				failures++;
			end else begin
				oldest = expected_results.pop_front();
				verdict_seen[res_beat.verdict]++;
				if (res_beat.keys_entered !== oldest.keys_entered) begin
					$error("keys_entered: expected %0d, got %0d",
						oldest.keys_entered, res_beat.keys_entered);
					failures++;
				end
				if (res_beat.lock_mode !== oldest.lock_mode) begin
					$error("lock_mode: expected %0d, got %0d",
						oldest.lock_mode, res_beat.lock_mode);
					failures++;
				end
				if (res_beat.verdict !== oldest.verdict) begin
					$error("verdict: expected %0d, got %0d",
						oldest.verdict, res_beat.verdict);
					failures++;
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_extremes();
		test_ignored_beats();
		test_user_unlock();
		test_alarm_and_clear();
		test_master_change();
		test_random_traffic();
		drain();
		if (expected_results.size() != 0) begin
			$error("%0d result beats never arrived", expected_results.size());
			failures++;
		end
		$display("covered %0d effective key/clear beats over four handshake phases",
			live_beats);
		$display("verdicts none/unlock/alarm/new-master/changed: %0d/%0d/%0d/%0d/%0d",
			verdict_seen[V_NONE], verdict_seen[V_UNLOCK], verdict_seen[V_ALARM],
			verdict_seen[V_NEWMODE], verdict_seen[V_CHANGED]);
		if (failures == 0)
			$display("keypad_code_lock regression: pass");
		else
			$display("keypad_code_lock regression: fail");
		$finish;
	end

endmodule
